// ===== src/gbn_pkg.sv =====
package gbn_pkg;

    // Payload split across the checksum lanes
    localparam int PAYLOAD_BYTES = 20;
    localparam int LANE_BYTES    = 4;
    localparam int NUM_LANES     = PAYLOAD_BYTES / LANE_BYTES;

    // Four signed bytes fit in 10 bits, twenty in 13 bits
    localparam int LANE_SUM_W = 10;
    localparam int BYTE_SUM_W = 13;
    localparam int CHK_W      = 32;

    // Largest retransmit burst
    localparam int BURST_MAX = 8;

    // Request operation codes
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    typedef logic signed [LANE_SUM_W-1:0] lane_sum_t;
    typedef logic [NUM_LANES-1:0][LANE_SUM_W-1:0] lane_sums_t;

    // One buffered packet
    typedef struct packed {
        logic [63:0]      low;
        logic [63:0]      mid;
        logic [31:0]      high;
        logic [CHK_W-1:0] checksum;
    } packet_t;

endpackage

// ===== src/go_back_n_sender_core.sv =====
// Channel   Handshake              Fields
// request   start / busy           operation, seq_number, ack_flag, checksum_in, payload_*
// config    cfg_we                 cfg_index, cfg_data
// packet    out_valid (1 cycle)    out_seq, out_checksum, out_payload_*, is_retransmit,
//                                  last_of_burst
//
// A send, ack or tick request holds busy through the merge and execute states, so no new
// request is taken before the last is done; a sent packet appears in the cycle busy drops.
// A timeout burst holds busy through the burst state and the drain of its last packet: the
// packet store has one read port with a registered read and gives one packet a cycle.
// Reset is asynchronous; after it the block is idle at once. The packet store is not
// cleared. The receiver cannot stall: each packet is shown for exactly one cycle.
module go_back_n_sender_core #(
    parameter int WINDOW   = 8,
    parameter int SEQ_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic [15:0]         seq_number,
    input  logic [19:0]         ack_flag,
    input  logic signed [31:0]  checksum_in,
    input  logic [63:0]         payload_low,
    input  logic [63:0]         payload_mid,
    input  logic [31:0]         payload_high,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                out_valid,
    output logic [15:0]         out_seq,
    output logic signed [31:0]  out_checksum,
    output logic [63:0]         out_payload_low,
    output logic [63:0]         out_payload_mid,
    output logic [31:0]         out_payload_high,
    output logic                is_retransmit,
    output logic                last_of_burst
);
    import gbn_pkg::*;

    localparam int AW  = $clog2(WINDOW);
    localparam int SW  = ((AW > 4) ? AW : 4) + 1;
    localparam int CAP = (WINDOW < BURST_MAX) ? WINDOW : BURST_MAX;
    localparam logic [3:0]    CAP_L   = 4'(CAP);
    localparam logic [SW-1:0] WIN_S   = SW'(WINDOW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_EXEC,
        S_BURST
    } state_t;

    // Ring slot arithmetic: the sum always stays below twice the depth
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] b, input logic [3:0] d);
        logic [SW-1:0] s;
        s = SW'(b) + SW'(d);
        if (s >= WIN_S)
        begin
            s = s - WIN_S;
        end
        return s[AW-1:0];
    endfunction

    // Configuration
    logic [15:0] timeout_reg;
    logic [3:0]  limit_reg;

    // Control state
    state_t               state_reg;
    logic [SEQ_BITS-1:0]  base_reg;
    logic [SEQ_BITS-1:0]  next_reg;
    logic [AW-1:0]        base_slot_reg;
    logic                 timer_run_reg;
    logic [15:0]          timer_cnt_reg;
    logic [3:0]           idx_reg;
    logic [3:0]           burst_n_reg;
    logic                 pend_reg;
    logic [15:0]          pend_seq_reg;
    logic                 pend_last_reg;

    // Captured request
    logic [1:0]       op_reg;
    logic [15:0]      seq_in_reg;
    logic [19:0]      ack_in_reg;
    logic [CHK_W-1:0] chk_in_reg;
    logic [63:0]      pay_low_reg;
    logic [63:0]      pay_mid_reg;
    logic [31:0]      pay_high_reg;
    lane_sums_t       lane_sum_reg;
    logic [CHK_W-1:0] send_chk_reg;
    logic [CHK_W-1:0] ack_chk_reg;

    // Result registers
    logic        out_valid_reg;
    logic [15:0] out_seq_reg;
    logic [31:0] out_chk_reg;
    logic [63:0] out_low_reg;
    logic [63:0] out_mid_reg;
    logic [31:0] out_high_reg;
    logic        out_retx_reg;
    logic        out_last_reg;

    logic                accept;
    logic [159:0]        payload_all;
    lane_sums_t          lane_sums;
    logic [CHK_W-1:0]    send_chk;
    logic [CHK_W-1:0]    ack_chk;
    logic [SEQ_BITS-1:0] outs;
    logic [3:0]          outs_small;
    logic [3:0]          lim_raw;
    logic [3:0]          lim_eff;
    logic                window_full;
    logic [31:0]         seq_ext;
    logic                seq_in_range;
    logic [SEQ_BITS-1:0] seq_m;
    logic [SEQ_BITS-1:0] ack_off;
    logic                ack_ok;
    logic [AW-1:0]       send_slot;
    logic [AW-1:0]       ack_slot;
    logic [15:0]         tick_limit;
    logic [16:0]         cnt_inc;
    logic                expire;
    logic [3:0]          burst_n;
    logic [AW-1:0]       burst_slot;
    logic [SEQ_BITS-1:0] burst_seq;
    logic                burst_last;
    logic                wr_en;
    logic                rd_en;
    packet_t             wr_data;
    packet_t             rd_data;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE) || pend_reg;

    // Checksum lanes on the incoming payload
    assign payload_all = {payload_high, payload_mid, payload_low};

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        lane_sum_t lane_out;

        gbn_sum_lane u_lane (
            .lane_bytes (payload_all[g*LANE_BYTES*8 +: LANE_BYTES*8]),
            .lane_sum   (lane_out)
        );

        assign lane_sums[g] = lane_out;
    end

    gbn_merge u_merge (
        .lane_sums (lane_sum_reg),
        .send_base (CHK_W'(next_reg)),
        .ack_base  (CHK_W'(seq_in_reg) + CHK_W'(ack_in_reg)),
        .send_chk  (send_chk),
        .ack_chk   (ack_chk)
    );

    // Window bookkeeping
    assign outs        = next_reg - base_reg;
    assign outs_small  = outs[3:0];
    assign lim_raw     = (limit_reg == 4'd0) ? 4'd1 : limit_reg;
    assign lim_eff     = (lim_raw > CAP_L) ? CAP_L : lim_raw;
    assign window_full = outs >= SEQ_BITS'(lim_eff);
    assign send_slot   = slot_add(base_slot_reg, outs_small);

    // Ack validation
    assign seq_ext      = 32'(seq_in_reg);
    assign seq_in_range = (seq_ext >> SEQ_BITS) == 32'd0;
    assign seq_m        = seq_ext[SEQ_BITS-1:0];
    assign ack_off      = seq_m - base_reg;
    assign ack_ok       = seq_in_range && (ack_chk_reg == chk_in_reg) && (ack_off < outs);
    assign ack_slot     = slot_add(base_slot_reg, ack_off[3:0] + 4'd1);

    // Retransmit timer
    assign tick_limit = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign cnt_inc    = {1'b0, timer_cnt_reg} + 17'd1;
    assign expire     = cnt_inc >= {1'b0, tick_limit};
    assign burst_n    = (outs > SEQ_BITS'(BURST_MAX)) ? 4'(BURST_MAX) : outs_small;

    // Burst read walk
    assign burst_slot = slot_add(base_slot_reg, idx_reg);
    assign burst_seq  = base_reg + SEQ_BITS'(idx_reg);
    assign burst_last = (idx_reg + 4'd1) == burst_n_reg;

    // Packet store access
    assign wr_en            = (state_reg == S_EXEC) && (op_reg == OP_SEND) && !window_full;
    assign wr_data.low      = pay_low_reg;
    assign wr_data.mid      = pay_mid_reg;
    assign wr_data.high     = pay_high_reg;
    assign wr_data.checksum = send_chk_reg;
    assign rd_en            = state_reg == S_BURST;

    gbn_store #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (send_slot),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (burst_slot),
        .rd_data (rd_data)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd12;
            limit_reg   <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_LIMIT:   limit_reg   <= cfg_data[3:0];
                default:     limit_reg   <= limit_reg;
            endcase
        end
    end

    // Capture the request and its checksums
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= operation;
            seq_in_reg   <= seq_number;
            ack_in_reg   <= ack_flag;
            chk_in_reg   <= checksum_in;
            pay_low_reg  <= payload_low;
            pay_mid_reg  <= payload_mid;
            pay_high_reg <= payload_high;
            lane_sum_reg <= lane_sums;
        end
        if (state_reg == S_MERGE)
        begin
            send_chk_reg <= send_chk;
            ack_chk_reg  <= ack_chk;
        end
    end

    // Sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= SEQ_BITS'(1);
            next_reg      <= SEQ_BITS'(1);
            base_slot_reg <= '0;
            timer_run_reg <= 1'b0;
            timer_cnt_reg <= '0;
            idx_reg       <= '0;
            burst_n_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_seq_reg  <= '0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_seq_reg   <= '0;
            out_chk_reg   <= '0;
            out_low_reg   <= '0;
            out_mid_reg   <= '0;
            out_high_reg  <= '0;
            out_retx_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;

            // Drain a packet read during the burst
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                out_seq_reg   <= pend_seq_reg;
                out_chk_reg   <= rd_data.checksum;
                out_low_reg   <= rd_data.low;
                out_mid_reg   <= rd_data.mid;
                out_high_reg  <= rd_data.high;
                out_retx_reg  <= 1'b1;
                out_last_reg  <= pend_last_reg;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_MERGE;
                    end
                end

                S_MERGE:
                begin
                    state_reg <= S_EXEC;
                end

                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    unique case (op_reg)
                        OP_SEND:
                        begin
                            // Stamp, buffer and emit; drop when the window is full
                            if (!window_full)
                            begin
                                out_valid_reg <= 1'b1;
                                out_seq_reg   <= 16'(next_reg);
                                out_chk_reg   <= send_chk_reg;
                                out_low_reg   <= pay_low_reg;
                                out_mid_reg   <= pay_mid_reg;
                                out_high_reg  <= pay_high_reg;
                                out_retx_reg  <= 1'b0;
                                out_last_reg  <= 1'b1;
                                if (outs == '0)
                                begin
                                    timer_run_reg <= 1'b1;
                                    timer_cnt_reg <= '0;
                                end
                                next_reg <= next_reg + SEQ_BITS'(1);
                            end
                        end

                        OP_ACK:
                        begin
                            // Advance the base cumulatively
                            if (ack_ok)
                            begin
                                base_reg      <= seq_m + SEQ_BITS'(1);
                                base_slot_reg <= ack_slot;
                                timer_cnt_reg <= '0;
                                timer_run_reg <= (seq_m + SEQ_BITS'(1)) != next_reg;
                            end
                        end

                        OP_TICK:
                        begin
                            if (timer_run_reg)
                            begin
                                if (expire)
                                begin
                                    timer_cnt_reg <= '0;
                                    if (burst_n != 4'd0)
                                    begin
                                        state_reg   <= S_BURST;
                                        idx_reg     <= '0;
                                        burst_n_reg <= burst_n;
                                    end
                                end
                                else
                                begin
                                    timer_cnt_reg <= cnt_inc[15:0];
                                end
                            end
                        end

                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_BURST:
                begin
                    // Read one outstanding packet a cycle, oldest first
                    pend_reg      <= 1'b1;
                    pend_seq_reg  <= 16'(burst_seq);
                    pend_last_reg <= burst_last;
                    idx_reg       <= idx_reg + 4'd1;
                    if (burst_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_seq          = out_seq_reg;
    assign out_checksum     = out_chk_reg;
    assign out_payload_low  = out_low_reg;
    assign out_payload_mid  = out_mid_reg;
    assign out_payload_high = out_high_reg;
    assign is_retransmit    = out_retx_reg;
    assign last_of_burst    = out_last_reg;

endmodule

// ===== src/gbn_sum_lane.sv =====
module gbn_sum_lane (
    input  logic [gbn_pkg::LANE_BYTES*8-1:0] lane_bytes,
    output gbn_pkg::lane_sum_t               lane_sum
);
    import gbn_pkg::*;

    lane_sum_t acc;

    // Add the lane's bytes as signed values
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < LANE_BYTES; i++)
        begin
            acc = acc + lane_sum_t'($signed(lane_bytes[i*8 +: 8]));
        end
    end

    assign lane_sum = acc;

endmodule

// ===== src/gbn_merge.sv =====
module gbn_merge (
    input  gbn_pkg::lane_sums_t         lane_sums,
    input  logic [gbn_pkg::CHK_W-1:0]   send_base,
    input  logic [gbn_pkg::CHK_W-1:0]   ack_base,
    output logic [gbn_pkg::CHK_W-1:0]   send_chk,
    output logic [gbn_pkg::CHK_W-1:0]   ack_chk
);
    import gbn_pkg::*;

    logic signed [BYTE_SUM_W-1:0] byte_sum;
    logic [CHK_W-1:0]             byte_sum_ext;

    // Combine the lane sums
    always_comb
    begin
        byte_sum = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            byte_sum = byte_sum + BYTE_SUM_W'($signed(lane_sums[i]));
        end
    end

    // Sign-extend and add the header terms
    assign byte_sum_ext = CHK_W'(byte_sum);
    assign send_chk     = send_base + byte_sum_ext;
    assign ack_chk      = ack_base + byte_sum_ext;

endmodule

// ===== src/gbn_store.sv =====
module gbn_store #(
    parameter int DEPTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  gbn_pkg::packet_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output gbn_pkg::packet_t rd_data
);
    import gbn_pkg::*;

    packet_t mem [DEPTH];
    packet_t rd_data_reg;

    // Write one packet
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    localparam int          WIN             = 8;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam int          DRAIN_CYCLES    = 16;
    localparam int          CYCLE_LIMIT     = 2_000_000;
    localparam int          N_PHASES        = 7;
    localparam int          ITEMS_PER_PHASE = 60;

    // One request as driven on the ports
    typedef struct {
        logic [1:0]  op;
        logic [15:0] seq;
        logic [19:0] ack;
        logic [31:0] chk;
        logic [63:0] lo;
        logic [63:0] mid;
        logic [31:0] hi;
    } req_t;

    // One packet the sender should emit
    typedef struct {
        logic [15:0] seq;
        packet_t     pkt;
        logic        retx;
        logic        last;
    } pkt_exp_t;

    // Directed row: payload is one fill byte; typed rows carry their own answer
    typedef struct {
        logic [1:0]  op;
        logic [15:0] seq;
        logic [19:0] ack;
        logic [31:0] chk;
        logic [7:0]  fill;
        int          reps;
        bit          fix_chk;
        bit          typed;
        bit          emit;
        logic [15:0] t_seq;
        logic [31:0] t_chk;
    } row_t;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic [1:0]  operation        = OP_SEND;
    logic [15:0] seq_number       = '0;
    logic [19:0] ack_flag         = '0;
    logic signed [31:0] checksum_in = '0;
    logic [63:0] payload_low      = '0;
    logic [63:0] payload_mid      = '0;
    logic [31:0] payload_high     = '0;
    logic        cfg_we           = 1'b0;
    logic        cfg_index        = CFG_TIMEOUT;
    logic [15:0] cfg_data         = '0;
    logic        out_valid;
    logic [15:0] out_seq;
    logic signed [31:0] out_checksum;
    logic [63:0] out_payload_low;
    logic [63:0] out_payload_mid;
    logic [31:0] out_payload_high;
    logic        is_retransmit;
    logic        last_of_burst;

    // Sender state mirror
    logic [15:0] win_base    = 16'd1;
    logic [15:0] next_seq    = 16'd1;
    logic [2:0]  ring_base   = '0;
    packet_t     ring [WIN];
    bit          timer_on    = 1'b0;
    int unsigned timer_ticks = 0;
    logic [15:0] timeout_reg = 16'd12;
    logic [3:0]  limit_reg   = 4'd8;

    pkt_exp_t    step_packets [$];
    pkt_exp_t    pending_packets [$];
    pkt_exp_t    head;
    int          mismatches = 0;
    int          cycles     = 0;

    logic [15:0] phase_timeout [N_PHASES] = '{16'd12, 16'd1, 16'd0, 16'd3,
                                               16'd65535, 16'd7, 16'd4};
    logic [3:0]  phase_limit   [N_PHASES] = '{4'd8, 4'd1, 4'd0, 4'd4, 4'd15, 4'd8, 4'd2};

    row_t plan [16] = '{
        //  op         seq       ack         chk            fill   n  fix typ emit t_seq  t_chk
        '{OP_SEND,   16'h0000, 20'h00000, 32'h0000_0000, 8'h00, 1, 0, 1, 1, 16'd1, 32'h0000_0001},
        '{OP_SEND,   16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 8'hFF, 1, 0, 1, 1, 16'd2, 32'hFFFF_FFEE},
        '{OP_SEND,   16'h0000, 20'h00000, 32'h0000_0000, 8'h7F, 1, 0, 1, 1, 16'd3, 32'h0000_09EF},
        '{OP_SEND,   16'h0000, 20'h00000, 32'h0000_0000, 8'h80, 1, 0, 1, 1, 16'd4, 32'hFFFF_F604},
        '{OP_UNUSED, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 8'hFF, 1, 0, 1, 0, 16'd0, 32'h0},
        '{OP_TICK,   16'h0000, 20'h00000, 32'h0000_0000, 8'h00, 1, 0, 0, 0, 16'd0, 32'h0},
        '{OP_ACK,    16'h0001, 20'h00000, 32'h0000_0000, 8'h00, 1, 0, 1, 0, 16'd0, 32'h0},
        '{OP_ACK,    16'h0000, 20'h00005, 32'h0000_0000, 8'h11, 1, 1, 1, 0, 16'd0, 32'h0},
        '{OP_ACK,    16'h0005, 20'h00000, 32'h0000_0000, 8'h22, 1, 1, 1, 0, 16'd0, 32'h0},
        '{OP_ACK,    16'h0002, 20'hFFFFF, 32'h0000_0000, 8'hFF, 1, 1, 0, 0, 16'd0, 32'h0},
        '{OP_TICK,   16'h0000, 20'h00000, 32'h0000_0000, 8'h00, 2, 0, 0, 0, 16'd0, 32'h0},
        '{OP_ACK,    16'h0004, 20'h00000, 32'h0000_0000, 8'hFF, 1, 1, 0, 0, 16'd0, 32'h0},
        '{OP_TICK,   16'h0000, 20'h00000, 32'h0000_0000, 8'h00, 1, 0, 1, 0, 16'd0, 32'h0},
        '{OP_SEND,   16'h0000, 20'h00000, 32'h0000_0000, 8'h5A, 8, 0, 0, 0, 16'd0, 32'h0},
        '{OP_SEND,   16'h0000, 20'h00000, 32'h8000_0000, 8'hA5, 1, 0, 1, 0, 16'd0, 32'h0},
        '{OP_ACK,    16'hFFFF, 20'hFFFFF, 32'h0000_0000, 8'h80, 1, 1, 1, 0, 16'd0, 32'h0}
    };

    go_back_n_sender_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .seq_number       (seq_number),
        .ack_flag         (ack_flag),
        .checksum_in      (checksum_in),
        .payload_low      (payload_low),
        .payload_mid      (payload_mid),
        .payload_high     (payload_high),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_seq          (out_seq),
        .out_checksum     (out_checksum),
        .out_payload_low  (out_payload_low),
        .out_payload_mid  (out_payload_mid),
        .out_payload_high (out_payload_high),
        .is_retransmit    (is_retransmit),
        .last_of_burst    (last_of_burst)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sum the twenty payload bytes as signed values
    function automatic logic [31:0] payload_sum(logic [63:0] lo, logic [63:0] mid,
                                                logic [31:0] hi);
        logic [31:0] total;
        total = '0;
        for (int i = 0; i < 8; i++)
        begin
            total += {{24{lo[8*i+7]}}, lo[8*i +: 8]};
            total += {{24{mid[8*i+7]}}, mid[8*i +: 8]};
        end
        for (int i = 0; i < 4; i++)
            total += {{24{hi[8*i+7]}}, hi[8*i +: 8]};
        return total;
    endfunction

    function automatic logic [31:0] ack_checksum(req_t r);
        return {16'd0, r.seq} + {12'd0, r.ack} + payload_sum(r.lo, r.mid, r.hi);
    endfunction

    function automatic int unsigned eff_limit();
        int unsigned l;
        l = limit_reg;
        if (l == 0) l = 1;
        if (l > WIN) l = WIN;
        if (l > BURST_MAX) l = BURST_MAX;
        return l;
    endfunction

    // Advance the sender mirror by one request; collect the packets it emits
    function automatic void predict_sender(req_t r);
        logic [15:0] outs;
        logic [15:0] off;
        logic [2:0]  slot;
        int unsigned lim;
        int unsigned n;
        outs = next_seq - win_base;
        step_packets.delete();
        case (r.op)
            OP_SEND:
            begin
                if (outs < eff_limit())
                begin
                    slot = ring_base + outs[2:0];
                    ring[slot] = '{low: r.lo, mid: r.mid, high: r.hi,
                                   checksum: {16'd0, next_seq} + payload_sum(r.lo, r.mid, r.hi)};
                    step_packets.push_back('{seq: next_seq, pkt: ring[slot],
                                             retx: 1'b0, last: 1'b1});
                    if (outs == 0)
                    begin
                        timer_on    = 1'b1;
                        timer_ticks = 0;
                    end
                    next_seq = next_seq + 16'd1;
                end
            end
            OP_ACK:
            begin
                off = r.seq - win_base;
                if (r.chk == ack_checksum(r) && off < outs)
                begin
                    win_base    = r.seq + 16'd1;
                    ring_base   = ring_base + off[2:0] + 3'd1;
                    timer_ticks = 0;
                    timer_on    = (win_base != next_seq);
                end
            end
            OP_TICK:
            begin
                if (timer_on)
                begin
                    lim = (timeout_reg == 0) ? 1 : timeout_reg;
                    timer_ticks++;
                    if (timer_ticks >= lim)
                    begin
                        timer_ticks = 0;
                        n = (outs > BURST_MAX) ? BURST_MAX : outs;
                        for (int i = 0; i < n; i++)
                        begin
                            slot = ring_base + 3'(i);
                            step_packets.push_back('{seq: win_base + 16'(i), pkt: ring[slot],
                                                     retx: 1'b1, last: (i + 1 == n)});
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Random fields everywhere, now and then an extreme fill byte
    function automatic req_t blank_request();
        req_t        r;
        logic [7:0]  fill;
        r.op  = OP_SEND;
        r.seq = 16'($urandom);
        r.ack = 20'($urandom);
        r.chk = $urandom;
        r.lo  = {$urandom, $urandom};
        r.mid = {$urandom, $urandom};
        r.hi  = $urandom;
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       fill = 8'h00;
                1:       fill = 8'hFF;
                2:       fill = 8'h7F;
                default: fill = 8'h80;
            endcase
            r.lo  = {8{fill}};
            r.mid = {8{fill}};
            r.hi  = {4{fill}};
        end
        return r;
    endfunction

    function automatic req_t valid_ack(logic [15:0] s);
        req_t r;
        r     = blank_request();
        r.op  = OP_ACK;
        r.seq = s;
        r.chk = ack_checksum(r);
        return r;
    endfunction

    // Mostly sends, in-window acks and ticks; some corrupt, stray and unused requests
    function automatic req_t random_request();
        req_t        r;
        logic [15:0] outs;
        int          pick;
        r    = blank_request();
        outs = next_seq - win_base;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.op = OP_SEND;
        else if (pick < 60)
        begin
            if (outs != 0)
                r = valid_ack(win_base + 16'($urandom_range(0, outs - 1)));
        end
        else if (pick < 85)
            r.op = OP_TICK;
        else if (pick < 90)
        begin
            r = valid_ack(win_base + 16'($urandom_range(0, 7)));
            r.chk ^= 32'd1 << $urandom_range(0, 31);
        end
        else if (pick < 95)
            r = valid_ack(next_seq + 16'($urandom_range(0, 65535 - outs)));
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    // Drive one request after a gap and hold it until the block takes it
    task automatic issue(req_t r, int gap, bit use_model);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= r.op;
        seq_number   <= r.seq;
        ack_flag     <= r.ack;
        checksum_in  <= r.chk;
        payload_low  <= r.lo;
        payload_mid  <= r.mid;
        payload_high <= r.hi;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        predict_sender(r);
        if (use_model)
            foreach (step_packets[i]) pending_packets.push_back(step_packets[i]);
    endtask

    // Drain the block, then write both registers
    task automatic write_config(logic [15:0] timeout_val, logic [3:0] limit_val);
        start <= 1'b0;
        while (pending_packets.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= timeout_val;
        @(posedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_data  <= {12'd0, limit_val};
        @(posedge clk);
        cfg_we      <= 1'b0;
        timeout_reg = timeout_val;
        limit_reg   = limit_val;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each emitted packet with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1)
        begin
            if (pending_packets.size() == 0)
            begin
                $display("%0t: packet seq %0d emitted with none expected", $time, out_seq);
                mismatches++;
            end
            else
            begin
                head = pending_packets.pop_front();
                check_field("out_seq", head.seq, out_seq);
                check_field("out_checksum", head.pkt.checksum, $unsigned(out_checksum));
                check_field("out_payload_low", head.pkt.low, out_payload_low);
                check_field("out_payload_mid", head.pkt.mid, out_payload_mid);
                check_field("out_payload_high", head.pkt.high, out_payload_high);
                check_field("is_retransmit", head.retx, is_retransmit);
                check_field("last_of_burst", head.last, last_of_burst);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        req_t r;
        bit   steady;
        foreach (ring[i]) ring[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short timeout so the directed ticks reach a resend
        write_config(16'd2, 4'd8);
        foreach (plan[k])
        begin
            for (int j = 0; j < plan[k].reps; j++)
            begin
                r.op  = plan[k].op;
                r.seq = plan[k].seq;
                r.ack = plan[k].ack;
                r.lo  = {8{plan[k].fill}};
                r.mid = {8{plan[k].fill}};
                r.hi  = {4{plan[k].fill}};
                r.chk = plan[k].fix_chk ? ack_checksum(r) : plan[k].chk;
                issue(r, $urandom_range(0, 7), !plan[k].typed);
                if (plan[k].typed && plan[k].emit)
                    pending_packets.push_back('{seq: plan[k].t_seq,
                        pkt: '{low: r.lo, mid: r.mid, high: r.hi, checksum: plan[k].t_chk},
                        retx: 1'b0, last: 1'b1});
            end
        end

        // Random phases over several register settings
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_config(phase_timeout[p], phase_limit[p]);
            steady = 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 15) == 0) steady = !steady;
                issue(random_request(), steady ? 0 : $urandom_range(0, 7), 1'b1);
            end
        end

        // Drain and report
        start <= 1'b0;
        for (int w = 0; w < 400 && pending_packets.size() != 0; w++) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_packets.size() != 0)
        begin
            $display("%0t: %0d expected packets never emitted", $time, pending_packets.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
